// File: hdl/mrrc_pkg.sv
// mrrc_pkg: shared types, constants and the crc-16 byte update for the
// modbus read response checker; no dependencies
package mrrc_pkg;

    localparam int MAX_FRAME_DEF = 16;

    localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
    localparam logic [7:0]  MIN_COUNT       = 8'd4;
    localparam int          MIN_FRAME       = 7;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  SLAVE_ID_RESET  = 8'd1;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_SHORT = 3'd1,
        ERR_ADDR  = 3'd2,
        ERR_FUNC  = 3'd3,
        ERR_CRC   = 3'd4,
        ERR_COUNT = 3'd5
    } err_code_t;

    typedef struct packed {
        logic       frame_ok;
        err_code_t  error_code;
        logic [31:0] raw_value;
        logic [4:0]  frame_length;
    } result_t;

    // reflected crc-16, one byte, unrolled over the eight bits
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/mrrc_frame.sv
// mrrc_frame: per-frame state (crc, byte count, tail window, header flags,
// data bytes) and the end-of-frame result; depends on mrrc_pkg
module mrrc_frame
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    input  logic [7:0] slave_address,
    output logic       res_valid,
    output result_t    res
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] count_reg, count_next, count_upd;
    logic [15:0]   crc_reg, crc_next, crc_upd;
    logic [15:0]   tail_reg, tail_next, tail_upd;
    logic [2:0]    flags_reg, flags_next, flags_upd;
    logic [31:0]   value_reg, value_next, value_upd;
    logic [15:0]   crc_rx;
    logic [CW+4:0] count_ext;
    err_code_t     err;

    always_comb
    begin
        count_upd = count_reg;
        crc_upd   = crc_reg;
        tail_upd  = tail_reg;
        flags_upd = flags_reg;
        value_upd = value_reg;
        if (count_reg < CW'(MAX_FRAME))
        begin
            if (count_reg >= CW'(2))
            begin
                crc_upd = crc_feed(crc_reg, tail_reg[15:8]);
            end
            tail_upd = {tail_reg[7:0], rx_byte};
            if (count_reg == CW'(0) && rx_byte == slave_address)
            begin
                flags_upd[0] = 1'b1;
            end
            if (count_reg == CW'(1) && rx_byte == FN_READ_HOLDING)
            begin
                flags_upd[1] = 1'b1;
            end
            if (count_reg == CW'(2) && rx_byte >= MIN_COUNT)
            begin
                flags_upd[2] = 1'b1;
            end
            // data bytes A B C D land high to low
            if (count_reg == CW'(3))
            begin
                value_upd[31:24] = rx_byte;
            end
            if (count_reg == CW'(4))
            begin
                value_upd[23:16] = rx_byte;
            end
            if (count_reg == CW'(5))
            begin
                value_upd[15:8] = rx_byte;
            end
            if (count_reg == CW'(6))
            begin
                value_upd[7:0] = rx_byte;
            end
            count_upd = count_reg + CW'(1);
        end
    end

    // received crc arrives low byte first
    assign crc_rx = {tail_upd[7:0], tail_upd[15:8]};

    always_comb
    begin
        if (count_upd < CW'(MIN_FRAME))
        begin
            err = ERR_SHORT;
        end
        else if (!flags_upd[0])
        begin
            err = ERR_ADDR;
        end
        else if (!flags_upd[1])
        begin
            err = ERR_FUNC;
        end
        else if (crc_rx != crc_upd)
        begin
            err = ERR_CRC;
        end
        else if (!flags_upd[2])
        begin
            err = ERR_COUNT;
        end
        else
        begin
            err = ERR_OK;
        end
    end

    assign count_ext = {5'd0, count_upd};

    always_comb
    begin
        res.frame_ok     = (err == ERR_OK);
        res.error_code   = err;
        res.raw_value    = (err == ERR_OK) ?
                           {value_upd[15:8], value_upd[7:0], value_upd[31:24], value_upd[23:16]} :
                           32'd0;
        res.frame_length = count_ext[4:0];
    end

    assign res_valid = accept & frame_end;

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        tail_next  = tail_reg;
        flags_next = flags_reg;
        value_next = value_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                count_next = '0;
                crc_next   = CRC_INIT;
                tail_next  = '0;
                flags_next = '0;
                value_next = '0;
            end
            else
            begin
                count_next = count_upd;
                crc_next   = crc_upd;
                tail_next  = tail_upd;
                flags_next = flags_upd;
                value_next = value_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            tail_reg  <= '0;
            flags_reg <= '0;
            value_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
            flags_reg <= flags_next;
            value_reg <= value_next;
        end
    end

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_FRAME))
        else $error("byte count above cap");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (count_reg == '0 && crc_reg == CRC_INIT && flags_reg == '0))
        else $error("frame state not cleared after frame end");

    a_failed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.frame_ok |-> res.raw_value == 32'd0)
        else $error("failed frame carries a value");

    a_short_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && count_upd < CW'(MIN_FRAME) |-> res.error_code == ERR_SHORT)
        else $error("short frame not flagged");

endmodule

// File: hdl/mrrc_obuf.sv
// mrrc_obuf: result register with a skid entry so a finished result can
// wait while bytes keep flowing; depends on mrrc_pkg
module mrrc_obuf
    import mrrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg & ~out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (main_valid_reg && !pop)
        begin
            if (push)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            main_valid_next = push;
            if (push)
            begin
                main_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without main entry");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");

    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> main_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved up");

endmodule

// File: hdl/modbus_read_response_checker.sv
// modbus_read_response_checker: top level, slave address register, frame
// state and result buffer; depends on mrrc_pkg, mrrc_frame, mrrc_obuf
//
//   transaction  handshake             payload
//   input        in_valid / in_stall   rx_byte, frame_end
//   output       out_valid / out_stall frame_ok, error_code, raw_value, frame_length
//   config       cfg_wr_en             cfg_wr_data (slave address)
//
// one byte per cycle while in_stall is low; the crc update and header
// checks sit between the frame state registers; the frame_end byte's result
// is registered in a two-entry result buffer, which lets bytes flow while a
// result waits; in_stall rises only when both entries are held.
// reset clears frame state, sets slave address to 1 and empties the buffer.
module modbus_read_response_checker
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_ok,
    output logic [2:0]  error_code,
    output logic [31:0] raw_value,
    output logic [4:0]  frame_length
);

    logic [7:0] slave_addr_reg, slave_addr_next;
    logic       accept;
    logic       res_valid;
    logic       buf_full;
    result_t    res;
    result_t    out_data;

    assign slave_addr_next = cfg_wr_en ? cfg_wr_data : slave_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ID_RESET;
        end
        else
        begin
            slave_addr_reg <= slave_addr_next;
        end
    end

    assign in_stall = buf_full;
    assign accept   = in_valid & ~buf_full;

    mrrc_frame #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .slave_address (slave_addr_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    mrrc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign frame_ok     = out_data.frame_ok;
    assign error_code   = out_data.error_code;
    assign raw_value    = out_data.raw_value;
    assign frame_length = out_data.frame_length;

    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_ok == (error_code == ERR_OK)))
        else $error("frame_ok disagrees with error code");

    a_cfg_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> slave_addr_reg == $past(cfg_wr_data))
        else $error("slave address not written");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !accept)
        else $error("byte taken while stalled");

endmodule
